@@ rtl/gpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Game port reader package
// Shared widths, button state codes, command codes and the result record.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int AXIS_COUNT  = 4;
    localparam int COUNT_W     = 16;
    localparam int STATUS_W    = 8;
    localparam int BTN_W       = 2;

    localparam logic [COUNT_W-1:0] LIMIT_MAX = 16'hFFFF;

    // Command codes of an input item.
    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Button states.
    localparam logic [BTN_W-1:0] BTN_INACTIVE = 2'd0;
    localparam logic [BTN_W-1:0] BTN_PRESSED  = 2'd1;
    localparam logic [BTN_W-1:0] BTN_HELD     = 2'd2;
    localparam logic [BTN_W-1:0] BTN_RELEASED = 2'd3;

    // Bit positions in the port byte.
    localparam int AXIS_BIT0   = 0;
    localparam int BUTTON_BIT0 = 4;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [BTN_W-1:0]   btn_state_t;

    typedef struct packed {
        count_t     axis_a_x;
        count_t     axis_a_y;
        count_t     axis_b_x;
        count_t     axis_b_y;
        btn_state_t button_a1_state;
        btn_state_t button_a2_state;
        btn_state_t button_b1_state;
        btn_state_t button_b2_state;
        logic       measuring;
        logic       not_found;
    } result_t;

endpackage

@@ rtl/gpr_sample_if.sv @@
// ----------------------------------------------------------------------------
// Game port sample channel
// Carries one port status byte and its command per request.
// ----------------------------------------------------------------------------
interface gpr_sample_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [gpr_pkg::STATUS_W-1:0]  port_status;

    modport source (output valid, output cmd, output port_status, input ready);
    modport sink   (input valid, input cmd, input port_status, output ready);
endinterface

@@ rtl/gpr_result_if.sv @@
// ----------------------------------------------------------------------------
// Game port result channel
// Carries axis counts, button states and measurement status per request.
// ----------------------------------------------------------------------------
interface gpr_result_if;
    logic                valid;
    logic                ready;
    gpr_pkg::count_t     axis_a_x;
    gpr_pkg::count_t     axis_a_y;
    gpr_pkg::count_t     axis_b_x;
    gpr_pkg::count_t     axis_b_y;
    gpr_pkg::btn_state_t button_a1_state;
    gpr_pkg::btn_state_t button_a2_state;
    gpr_pkg::btn_state_t button_b1_state;
    gpr_pkg::btn_state_t button_b2_state;
    logic                measuring;
    logic                not_found;

    modport source (
        output valid, output axis_a_x, output axis_a_y, output axis_b_x,
        output axis_b_y, output button_a1_state, output button_a2_state,
        output button_b1_state, output button_b2_state, output measuring,
        output not_found, input ready
    );
    modport sink (
        input valid, input axis_a_x, input axis_a_y, input axis_b_x,
        input axis_b_y, input button_a1_state, input button_a2_state,
        input button_b1_state, input button_b2_state, input measuring,
        input not_found, output ready
    );
endinterface

@@ rtl/gpr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Game port configuration channel
// Carries a new poll limit per write request.
// ----------------------------------------------------------------------------
interface gpr_cfg_if;
    logic            valid;
    logic            ready;
    gpr_pkg::count_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/game_port_axis_and_button_reader.sv @@
// ----------------------------------------------------------------------------
// Game port axis and button reader
// Times four one-shot axes and tracks four active-low buttons.
// ----------------------------------------------------------------------------
// Usage:
// The sample channel takes one port status byte per request. A start request
// ages and updates the button states, clears the axis counters and opens a
// measurement; each poll request then counts every axis whose one-shot bit is
// still high. The measurement closes when all axes have dropped or after
// poll_limit polls. Every sample request yields exactly one result request.
// The cfg channel writes poll_limit (reset 65535); it is always ready.
// Each accepted sample's result is registered; one sample is taken every
// cycle while sample ready is high. The whole update is one pass of five
// 16-bit incrementers and limit compares between the state registers and
// the result register. A second result register holds one extra result, so
// a sample is still taken while the receiver stalls; sample ready drops only
// when both result registers are full. Reset clears the counters, sets the
// axes to finished, the buttons to inactive and empties the result registers.
// ----------------------------------------------------------------------------
module game_port_axis_and_button_reader (
    input  logic                 clk,
    input  logic                 rst_n,
    gpr_sample_if.sink           sample,
    gpr_result_if.source         result,
    gpr_cfg_if.sink              cfg
);

    localparam int N = gpr_pkg::AXIS_COUNT;

    gpr_pkg::count_t     poll_limit_reg;
    gpr_pkg::count_t     axis_count_reg    [N];
    gpr_pkg::count_t     axis_count_next   [N];
    logic [N-1:0]        axis_done_reg;
    logic [N-1:0]        axis_done_next;
    gpr_pkg::count_t     polls_reg;
    gpr_pkg::count_t     polls_next;
    logic                active_reg;
    logic                active_next;
    gpr_pkg::btn_state_t button_reg        [N];
    gpr_pkg::btn_state_t button_next       [N];
    gpr_pkg::count_t     eff_limit;
    gpr_pkg::result_t    result_next;
    gpr_pkg::result_t    main_reg;
    gpr_pkg::result_t    skid_reg;
    logic                main_valid_reg;
    logic                skid_valid_reg;
    logic                accept;
    logic                out_fire;

    function automatic gpr_pkg::btn_state_t button_update(
        input gpr_pkg::btn_state_t cur,
        input logic                down
    );
        gpr_pkg::btn_state_t s;
        s = cur;
        unique case (cur)
            gpr_pkg::BTN_PRESSED:  s = gpr_pkg::BTN_HELD;
            gpr_pkg::BTN_RELEASED: s = gpr_pkg::BTN_INACTIVE;
            default:               s = cur;
        endcase
        if (down)
        begin
            if (s == gpr_pkg::BTN_INACTIVE)
            begin
                s = gpr_pkg::BTN_PRESSED;
            end
        end
        else if (s == gpr_pkg::BTN_PRESSED || s == gpr_pkg::BTN_HELD)
        begin
            s = gpr_pkg::BTN_RELEASED;
        end
        return s;
    endfunction

    assign cfg.ready    = 1'b1;
    assign sample.ready = !skid_valid_reg;
    assign accept       = sample.valid && !skid_valid_reg;
    assign out_fire     = main_valid_reg && result.ready;

    // A zero limit behaves as one.
    assign eff_limit = (poll_limit_reg == '0) ? gpr_pkg::count_t'(1) : poll_limit_reg;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            axis_count_next[i] = axis_count_reg[i];
            axis_done_next[i]  = axis_done_reg[i];
            button_next[i]     = button_reg[i];
        end
        polls_next  = polls_reg;
        active_next = active_reg;

        if (sample.cmd == gpr_pkg::CMD_START)
        begin
            for (int i = 0; i < N; i++)
            begin
                button_next[i] = button_update(button_reg[i],
                                   !sample.port_status[gpr_pkg::BUTTON_BIT0 + i]);
                axis_count_next[i] = '0;
                axis_done_next[i]  = 1'b0;
            end
            polls_next  = '0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (!axis_done_reg[i])
                begin
                    if (!sample.port_status[gpr_pkg::AXIS_BIT0 + i])
                    begin
                        axis_done_next[i] = 1'b1;
                    end
                    else if (axis_count_reg[i] != gpr_pkg::LIMIT_MAX)
                    begin
                        axis_count_next[i] = axis_count_reg[i] + 1'b1;
                    end
                end
            end
            if (polls_reg != gpr_pkg::LIMIT_MAX)
            begin
                polls_next = polls_reg + 1'b1;
            end
            if ((&axis_done_next) || (polls_next >= eff_limit))
            begin
                active_next = 1'b0;
            end
        end

        result_next.axis_a_x        = axis_count_next[0];
        result_next.axis_a_y        = axis_count_next[1];
        result_next.axis_b_x        = axis_count_next[2];
        result_next.axis_b_y        = axis_count_next[3];
        result_next.button_a1_state = button_next[0];
        result_next.button_a2_state = button_next[1];
        result_next.button_b1_state = button_next[2];
        result_next.button_b2_state = button_next[3];
        result_next.measuring       = active_next;
        result_next.not_found       = (axis_count_next[0] == eff_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= gpr_pkg::LIMIT_MAX;
            for (int i = 0; i < N; i++)
            begin
                axis_count_reg[i] <= '0;
                button_reg[i]     <= gpr_pkg::BTN_INACTIVE;
            end
            axis_done_reg <= '1;
            polls_reg     <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                poll_limit_reg <= cfg.data;
            end
            if (accept)
            begin
                for (int i = 0; i < N; i++)
                begin
                    axis_count_reg[i] <= axis_count_next[i];
                    button_reg[i]     <= button_next[i];
                end
                axis_done_reg <= axis_done_next;
                polls_reg     <= polls_next;
                active_reg    <= active_next;
            end
        end
    end

    // Result register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (!main_valid_reg || out_fire)
                begin
                    main_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    main_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!main_valid_reg || out_fire)
            begin
                main_reg <= result_next;
            end
            else
            begin
                skid_reg <= result_next;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
    end

    assign result.valid           = main_valid_reg;
    assign result.axis_a_x        = main_reg.axis_a_x;
    assign result.axis_a_y        = main_reg.axis_a_y;
    assign result.axis_b_x        = main_reg.axis_b_x;
    assign result.axis_b_y        = main_reg.axis_b_y;
    assign result.button_a1_state = main_reg.button_a1_state;
    assign result.button_a2_state = main_reg.button_a2_state;
    assign result.button_b1_state = main_reg.button_b1_state;
    assign result.button_b2_state = main_reg.button_b2_state;
    assign result.measuring       = main_reg.measuring;
    assign result.not_found       = main_reg.not_found;

endmodule
